// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check at each clock edge outside reset
`define KWM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at each clock edge, reset included
`define KWM_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/kwm_pkg.sv =====
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int VALUE_W     = 32;
  localparam int ID_W        = 3;
  localparam int ACTIVE_W    = 4;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_MERGED = 2'd0,
    ST_FULL   = 2'd1,
    ST_CLOSED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic ins;
    logic close;
    logic pop;
    logic clear;
  } list_cmd_t;

endpackage

// ===== hw/rtl/kwm_store.sv =====
`timescale 1ns / 1ps

module kwm_store import kwm_pkg::*; #(
  parameter int ENTRIES = 64,
  localparam int ADDR_W = $clog2(ENTRIES)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/kwm_lists.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kwm_lists import kwm_pkg::*; #(
  parameter int LISTS = 8,
  parameter int BUFFER_DEPTH = 8,
  localparam int LIST_W  = $clog2(LISTS),
  localparam int DEPTH_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
  localparam int FILL_W  = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIST_W-1:0]  addr,
  input  list_cmd_t          cmd,
  output logic [DEPTH_W-1:0] rd_pos,
  output logic [FILL_W-1:0]  rd_fill,
  output logic [LISTS-1:0]   closed,
  output logic [LISTS-1:0]   empty
);

  logic [DEPTH_W-1:0] pos [LISTS];
  logic [FILL_W-1:0]  fill [LISTS];
  logic [LISTS-1:0]   closed_q;
  logic [LISTS-1:0]   empty_q;

  assign rd_pos  = pos[addr];
  assign rd_fill = fill[addr];
  assign closed  = closed_q;
  assign empty   = empty_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LISTS; i++) begin
        pos[i]  <= '0;
        fill[i] <= '0;
      end
      closed_q <= '0;
      empty_q  <= '1;
    end else begin
      if (cmd.ins) begin
        fill[addr]    <= fill[addr] + 1'b1;
        empty_q[addr] <= 1'b0;
      end
      if (cmd.pop) begin
        pos[addr]  <= (pos[addr] == DEPTH_W'(BUFFER_DEPTH - 1)) ? '0 : pos[addr] + 1'b1;
        fill[addr] <= fill[addr] - 1'b1;
        if (fill[addr] == FILL_W'(1)) begin
          empty_q[addr] <= 1'b1;
        end
      end
      if (cmd.close) begin
        closed_q[addr] <= 1'b1;
      end
      if (cmd.clear) begin
        closed_q <= '0;
      end
    end
  end

  `KWM_ASSERT(a_pop_nonempty, cmd.pop |-> !empty_q[addr], "pop from an empty list")
  `KWM_ASSERT(a_ins_room, cmd.ins |-> (fill[addr] != FILL_W'(BUFFER_DEPTH)), "insert into a full list")

endmodule

// ===== hw/rtl/k_way_sorted_merge.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// K-way merge of ascending signed streams. Each input transfer carries an element
// and/or an end mark for one list; elements wait in a per-list circular buffer held
// in one single-port-read memory. An item with no emission passes through accept,
// buffer update and merge check. For each emitted element the smallest head is
// found by a serial scan of the active lists (active_lists, capped at LISTS), one
// memory read per cycle, followed by a compare, the pop and the next check, which
// the final element of a job skips. Ties go to the lower list number. status
// reports drops (1: buffer full, 2: list closed or inactive); last_of_merge marks
// the final element once every active list is closed and drained, after which a
// new job starts with all lists open. The output register lets the block keep
// working while one result waits for transfer.
module k_way_sorted_merge import kwm_pkg::*; #(
  parameter int LISTS = 8,
  parameter int BUFFER_DEPTH = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ACTIVE_W-1:0]       cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ID_W-1:0]           list_id,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      carries_value,
  input  logic                      ends_list,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] merged_value,
  output logic [ID_W-1:0]           source_list,
  output logic [STATUS_W-1:0]       status,
  output logic                      last_of_merge
);

  localparam int LIST_W  = $clog2(LISTS);
  localparam int DEPTH_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FILL_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W   = FILL_W + 1;
  localparam int ENTRIES = LISTS * BUFFER_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int ACT_W   = ($clog2(LISTS + 1) > ACTIVE_W) ? $clog2(LISTS + 1) : ACTIVE_W;

  state_t state, state_next;
  logic [ACTIVE_W-1:0] active_lists;
  logic [ACT_W-1:0]    act;
  logic [LISTS-1:0]    act_mask;

  logic [ID_W-1:0]    id_q;
  logic [VALUE_W-1:0] val_q;
  logic               has_val_q;
  logic               ends_q;
  logic [LIST_W-1:0]  id_ptr;

  logic [RES_W-1:0]   n_res;
  logic               n_inc;

  logic [LIST_W-1:0]  scan_idx;
  logic               scan_start;
  logic               issue;
  logic               rd_pend;
  logic               rd_live;
  logic [LIST_W-1:0]  rd_list;
  logic               best_found;
  logic [LIST_W-1:0]  best_list;
  logic [VALUE_W-1:0] best_val;

  logic [LIST_W-1:0]  ptr;
  list_cmd_t          cmd;
  logic [DEPTH_W-1:0] pos_rd;
  logic [FILL_W-1:0]  fill_rd;
  logic [LISTS-1:0]   closed_v;
  logic [LISTS-1:0]   empty_v;

  logic               wr_en;
  logic [ADDR_W-1:0]  list_base;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic [SUM_W-1:0]   slot_sum;
  logic [SUM_W-1:0]   slot_wrap;

  logic               usable;
  logic               full;
  logic               need_drop;
  logic               can_emit;
  logic               blocked;
  logic               found;
  logic               all_done;
  logic               others_done;
  logic               last_hit;
  logic [LISTS-1:0]   best_onehot;

  logic               load_out;
  logic [VALUE_W-1:0] load_value;
  logic [ID_W-1:0]    load_src;
  status_t            load_status;
  logic               load_last;
  status_t            status_q;

  assign in_stall = (state != S_IDLE);
  assign status   = status_q;

  assign act = (ACT_W'(active_lists) > ACT_W'(LISTS)) ? ACT_W'(LISTS) : ACT_W'(active_lists);

  always_comb begin
    for (int i = 0; i < LISTS; i++) begin
      act_mask[i] = ACT_W'(i) < act;
    end
  end

  assign id_ptr    = LIST_W'(id_q);
  assign usable    = (ACT_W'(id_q) < act) && !closed_v[id_ptr];
  assign full      = (fill_rd == FILL_W'(BUFFER_DEPTH));
  assign need_drop = has_val_q && (!usable || full);
  assign can_emit  = !out_valid || !out_stall;

  assign blocked  = |(act_mask & empty_v & ~closed_v);
  assign found    = |(act_mask & ~empty_v);
  assign all_done = ~|(act_mask & ~(closed_v & empty_v));

  assign best_onehot = LISTS'(1) << best_list;
  assign others_done = ~|(act_mask & ~(closed_v & empty_v) & ~best_onehot);
  assign last_hit    = others_done && closed_v[best_list] && (fill_rd == FILL_W'(1));

  assign slot_sum  = SUM_W'(pos_rd) + SUM_W'(fill_rd);
  assign slot_wrap = (slot_sum >= SUM_W'(BUFFER_DEPTH)) ? slot_sum - SUM_W'(BUFFER_DEPTH)
                                                        : slot_sum;
  assign list_base = ADDR_W'(ptr) * ADDR_W'(BUFFER_DEPTH);
  assign wr_addr   = list_base + ADDR_W'(DEPTH_W'(slot_wrap));
  assign rd_addr   = list_base + ADDR_W'(pos_rd);

  always_comb begin
    state_next  = state;
    ptr         = id_ptr;
    cmd         = '0;
    wr_en       = 1'b0;
    n_inc       = 1'b0;
    scan_start  = 1'b0;
    issue       = 1'b0;
    load_out    = 1'b0;
    load_value  = val_q;
    load_src    = id_q;
    load_status = ST_MERGED;
    load_last   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        if (!need_drop || can_emit) begin
          wr_en     = has_val_q && usable && !full;
          cmd.ins   = has_val_q && usable && !full;
          cmd.close = ends_q && usable;
          if (need_drop) begin
            load_out    = 1'b1;
            load_status = usable ? ST_FULL : ST_CLOSED;
            n_inc       = 1'b1;
          end
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (blocked || !found || n_res == RES_W'(MAX_RESULTS)) begin
          cmd.clear  = all_done;
          state_next = S_IDLE;
        end else begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ptr   = scan_idx;
        issue = 1'b1;
        if (ACT_W'(scan_idx) + ACT_W'(1) == act) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        ptr = best_list;
        if (can_emit) begin
          cmd.pop    = 1'b1;
          load_out   = 1'b1;
          load_value = best_val;
          load_src   = ID_W'(best_list);
          load_last  = last_hit;
          n_inc      = 1'b1;
          if (last_hit) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_lists <= ACTIVE_W'(8);
      n_res        <= '0;
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
      best_found   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cfg_wr_en) begin
        active_lists <= cfg_wr_data;
      end
      if (state == S_IDLE && in_valid) begin
        n_res <= '0;
      end else if (n_inc) begin
        n_res <= n_res + 1'b1;
      end
      if (scan_start) begin
        scan_idx   <= '0;
        best_found <= 1'b0;
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (rd_pend && rd_live && (!best_found || $signed(rd_data) < $signed(best_val))) begin
        best_found <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      id_q      <= list_id;
      val_q     <= value;
      has_val_q <= carries_value;
      ends_q    <= ends_list;
    end
    rd_live <= !empty_v[scan_idx];
    rd_list <= scan_idx;
    if (rd_pend && rd_live && (!best_found || $signed(rd_data) < $signed(best_val))) begin
      best_val  <= rd_data;
      best_list <= rd_list;
    end
    if (load_out) begin
      merged_value  <= load_value;
      source_list   <= load_src;
      status_q      <= load_status;
      last_of_merge <= load_last;
    end
  end

  kwm_lists #(
    .LISTS        (LISTS),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_lists (
    .clk     (clk),
    .rst     (rst),
    .addr    (ptr),
    .cmd     (cmd),
    .rd_pos  (pos_rd),
    .rd_fill (fill_rd),
    .closed  (closed_v),
    .empty   (empty_v)
  );

  kwm_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_q),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  `KWM_ASSERT(a_load_free, load_out |-> (!out_valid || !out_stall), "result loaded over a waiting result")
  `KWM_ASSERT(a_emit_best, (state == S_EMIT) |-> best_found, "emit without a selected head")
  `KWM_ASSERT(a_result_cap, n_inc |-> (n_res < RES_W'(MAX_RESULTS)), "result cap exceeded")
  `KWM_ASSERT_RST(a_reset_quiet, rst |=> !out_valid, "output valid after reset")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import kwm_pkg::*;

  localparam int LISTS = 8;
  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic signed [VALUE_W-1:0] val;
    logic has_val;
    logic ends;
  } stream_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic [ID_W-1:0] src;
    status_t st;
    logic last;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [ACTIVE_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ID_W-1:0] list_id = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic carries_value = 1'b0;
  logic ends_list = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_W-1:0] merged_value;
  logic [ID_W-1:0] source_list;
  logic [STATUS_W-1:0] status;
  logic last_of_merge;

  // predictor state
  logic signed [VALUE_W-1:0] list_buf [LISTS][DEPTH];
  int unsigned list_head [LISTS];
  int unsigned list_fill [LISTS];
  bit list_done [LISTS];
  logic [ACTIVE_W-1:0] active_reg;
  merge_result_t pending_merged [$];
  merge_result_t want;

  // stimulus state
  int cur_active = LISTS;
  int gen_left [LISTS];
  bit gen_open [LISTS];
  longint gen_prev [LISTS];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_out = 1'b0;

  int errors = 0;
  int cycles = 0;

  k_way_sorted_merge dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .list_id(list_id),
    .value(value),
    .carries_value(carries_value),
    .ends_list(ends_list),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .merged_value(merged_value),
    .source_list(source_list),
    .status(status),
    .last_of_merge(last_of_merge)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk)
    out_stall <= hold_out || ($urandom_range(99) < recv_idle_pct);

  function automatic bit job_finished(input int act);
    int i;
    for (i = 0; i < act; i++)
      if (!list_done[i] || list_fill[i] != 0)
        return 1'b0;
    return 1'b1;
  endfunction

  task automatic merge_step(input stream_item_t it);
    int act, n, best, i;
    bit usable, found, blocked, last_flag;
    logic signed [VALUE_W-1:0] head_val;
    act = (active_reg > LISTS) ? LISTS : int'(active_reg);
    usable = (int'(it.id) < act) && !list_done[it.id];
    n = 0;
    if (it.has_val) begin
      if (!usable) begin
        pending_merged.push_back('{it.val, it.id, ST_CLOSED, 1'b0});
        n++;
      end else if (list_fill[it.id] >= DEPTH) begin
        pending_merged.push_back('{it.val, it.id, ST_FULL, 1'b0});
        n++;
      end else begin
        list_buf[it.id][(list_head[it.id] + list_fill[it.id]) % DEPTH] = it.val;
        list_fill[it.id]++;
      end
    end
    if (it.ends && usable)
      list_done[it.id] = 1'b1;
    while (n < MAX_RESULTS) begin
      found = 1'b0;
      blocked = 1'b0;
      best = 0;
      for (i = 0; i < act; i++) begin
        if (list_fill[i] == 0) begin
          if (!list_done[i])
            blocked = 1'b1;
        end else if (!found || list_buf[i][list_head[i]] < list_buf[best][list_head[best]]) begin
          found = 1'b1;
          best = i;
        end
      end
      if (blocked || !found)
        break;
      head_val = list_buf[best][list_head[best]];
      list_head[best] = (list_head[best] + 1) % DEPTH;
      list_fill[best]--;
      last_flag = job_finished(act);
      pending_merged.push_back('{head_val, best[ID_W-1:0], ST_MERGED, last_flag});
      n++;
      if (last_flag)
        break;
    end
    if (job_finished(act))
      foreach (list_done[k])
        list_done[k] = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    errors++;
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, exp_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (list_head[k]) begin
        list_head[k] = 0;
        list_fill[k] = 0;
        list_done[k] = 1'b0;
      end
      active_reg = LISTS;
      pending_merged.delete();
    end else begin
      if (cfg_wr_en)
        active_reg = cfg_wr_data;
      if (in_valid && !in_stall)
        merge_step('{list_id, value, carries_value, ends_list});
      if (out_valid && !out_stall) begin
        if (pending_merged.size() == 0) begin
          report_mismatch("unexpected transfer, merged_value", merged_value, 0);
        end else begin
          want = pending_merged.pop_front();
          if (merged_value !== want.val)
            report_mismatch("merged_value", merged_value, want.val);
          if (source_list !== want.src)
            report_mismatch("source_list", source_list, want.src);
          if (status !== want.st)
            report_mismatch("status", status, want.st);
          if (last_of_merge !== want.last)
            report_mismatch("last_of_merge", last_of_merge, want.last);
        end
      end
    end
  end

  function automatic stream_item_t item_of(input int id, input longint v, input bit hv,
                                           input bit e);
    return '{id[ID_W-1:0], v[VALUE_W-1:0], hv, e};
  endfunction

  task automatic send_item(input stream_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    list_id <= it.id;
    value <= it.val;
    carries_value <= it.has_val;
    ends_list <= it.ends;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_merged.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_active(input int n);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n[ACTIVE_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_active = n;
  endtask

  // one merge job of ascending lists over the active lists, randomly interleaved
  task automatic sorted_job(input int max_len, input bit broken, inout int sent);
    int act, i, live;
    bit narrow;
    longint room, inc;
    stream_item_t it;
    act = (cur_active > LISTS) ? LISTS : cur_active;
    narrow = $urandom_range(1);
    for (i = 0; i < act; i++) begin
      gen_left[i] = $urandom_range(max_len);
      gen_open[i] = 1'b1;
      gen_prev[i] = narrow ? longint'($urandom_range(6)) - 3 : longint'($signed($urandom()));
    end
    live = act;
    while (live > 0) begin
      i = $urandom_range(act - 1);
      while (!gen_open[i])
        i = (i + 1) % act;
      it = item_of(i, $urandom(), 1'b0, 1'b0);
      if (gen_left[i] > 0) begin
        room = (64'sd2147483647 - gen_prev[i]) / (gen_left[i] + 1);
        inc = narrow ? longint'($urandom_range(2)) : ({$urandom(), $urandom()} % (room + 1));
        gen_prev[i] = gen_prev[i] + inc;
        it.val = gen_prev[i][VALUE_W-1:0];
        it.has_val = 1'b1;
        gen_left[i]--;
        it.ends = (gen_left[i] == 0) && $urandom_range(1);
      end else begin
        it.ends = 1'b1;
      end
      if (it.ends) begin
        gen_open[i] = 1'b0;
        live--;
      end
      send_item(it);
      sent++;
      if (broken && it.ends && $urandom_range(3) == 0) begin
        send_item(item_of(i, gen_prev[i] + 1, 1'b1, $urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic random_phase(input int items);
    int sent, pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 30)
        set_active(pick < 3 ? 15 : $urandom_range(LISTS));
      if (cur_active == 0 || pick >= 85) begin
        repeat ($urandom_range(8, 1)) begin
          send_item(item_of($urandom_range(LISTS - 1), $urandom(), $urandom_range(1),
                            $urandom_range(1)));
          sent++;
        end
      end else begin
        sorted_job(10, pick >= 70, sent);
      end
    end
  endtask

  task automatic test_tie_and_extremes();
    set_active(3);
    send_item(item_of(0, -64'sd2147483648, 1'b1, 1'b0));
    send_item(item_of(1, 5, 1'b1, 1'b0));
    send_item(item_of(2, 5, 1'b1, 1'b0));
    send_item(item_of(0, 5, 1'b1, 1'b1));
    send_item(item_of(1, 64'sd2147483647, 1'b1, 1'b1));
    send_item(item_of(2, 0, 1'b0, 1'b1));
  endtask

  task automatic test_drops();
    int i;
    set_active(2);
    for (i = 0; i < DEPTH; i++)
      send_item(item_of(0, i * 3 - 7, 1'b1, 1'b0));
    send_item(item_of(0, 100, 1'b1, 1'b1));
    send_item(item_of(0, 101, 1'b1, 1'b0));
    send_item(item_of(5, -1, 1'b1, 1'b0));
    send_item(item_of(5, 0, 1'b0, 1'b1));
    send_item(item_of(0, 0, 1'b0, 1'b1));
    send_item(item_of(1, 0, 1'b0, 1'b1));
  endtask

  task automatic test_register_extremes();
    set_active(0);
    send_item(item_of(3, 42, 1'b1, 1'b1));
    set_active(15);
    send_item(item_of(6, 9, 1'b1, 1'b0));
    set_active(2);
    send_item(item_of(0, 1, 1'b1, 1'b1));
    send_item(item_of(1, 2, 1'b1, 1'b1));
  endtask

  task automatic test_backpressure();
    int sent;
    sent = 0;
    set_active(LISTS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
      sorted_job(12, 1'b0, sent);
    join
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 37;
    recv_idle_pct = 69;
    random_phase(100);
    send_idle_pct = 69;
    recv_idle_pct = 37;
    random_phase(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(100);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_tie_and_extremes();
    test_drops();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (errors == 0 && pending_merged.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== k_way_sorted_merge.f =====
+incdir+hw/rtl
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_store.sv
hw/rtl/kwm_lists.sv
hw/rtl/k_way_sorted_merge.sv
tb/sv/tb_top.sv
